FILE: hdl/sga_pkg.sv
// Shared types and constants for the softened gravity acceleration block.
// No dependencies; every other file in hdl/ imports this package.
package sga_pkg;

  localparam int MAX_STARS_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int CRD_W         = 32;
  localparam int ACC_W         = 48;
  localparam int CFG_CNT_W     = 11;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;
  localparam int Q_DEPTH       = 2;

  // divider sized for the widest use: mass * cosine over r2 * 64
  localparam int DIV_NUM_W = 63;
  localparam int DIV_DEN_W = 56;

  localparam logic [1:0] REG_CENTRAL = 2'd0;
  localparam logic [1:0] REG_SOFT    = 2'd1;
  localparam logic [1:0] REG_PAIR    = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [30:0]        U_ONE     = 31'h4000_0000;
  localparam logic [62:0]        TERM_HUGE = 63'h0100_0000_0000_0000;
  localparam logic signed [65:0] ACC_LIM   = 66'sh0_4000_0000_0000_0000;
  localparam logic signed [63:0] OUT_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN   = -64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        star_index;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic [CRD_W-1:0]        star_mass;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_index;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic                    saturated;
    logic                    index_error;
  } out_item_t;

  typedef struct packed {
    logic [CRD_W-1:0] central_mass;
    logic [CRD_W-1:0] softening_length;
    logic             pairwise_enable;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic [CRD_W-1:0]        mass;
  } q_item_t;

endpackage

FILE: hdl/sga_front.sv
// Front end: configuration registers and command classification.
// Depends on sga_pkg; feeds sga_queue.
module sga_front #(
  parameter int MAX_STARS = sga_pkg::MAX_STARS_DEF,
  localparam int CNT_W = $clog2(MAX_STARS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sga_pkg::in_item_t            in_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sga_pkg::PADDR_W-1:0]  paddr,
  input  logic [sga_pkg::PDATA_W-1:0]  pwdata,
  output logic [sga_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         q_full,
  output logic                         push,
  output sga_pkg::q_item_t             push_item,
  output sga_pkg::cfg_t                cfg,
  output logic [CNT_W-1:0]             count
);
  import sga_pkg::*;

  logic [CRD_W-1:0]     central_r, soft_r;
  logic                 pair_r;
  logic [CFG_CNT_W-1:0] count_cfg_r;
  logic                 wr;
  logic                 keep;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      central_r   <= '0;
      soft_r      <= 32'h0001_0000;
      pair_r      <= 1'b1;
      count_cfg_r <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CENTRAL: central_r   <= pwdata;
        REG_SOFT:    soft_r      <= pwdata;
        REG_PAIR:    pair_r      <= pwdata[0];
        REG_COUNT:   count_cfg_r <= pwdata[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTRAL: prdata = central_r;
      REG_SOFT:    prdata = soft_r;
      REG_PAIR:    prdata = {31'd0, pair_r};
      REG_COUNT:   prdata = {21'd0, count_cfg_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.central_mass     = central_r;
  assign cfg.softening_length = soft_r;
  assign cfg.pairwise_enable  = pair_r;

  // counts above the store depth act as the depth
  assign count = (32'(count_cfg_r) > 32'(MAX_STARS)) ? CNT_W'(MAX_STARS)
                                                      : CNT_W'(count_cfg_r);

  always_comb begin
    push_item.idx  = in_data.star_index;
    push_item.x    = in_data.pos_x;
    push_item.y    = in_data.pos_y;
    push_item.mass = in_data.star_mass;
    keep           = 1'b1;
    if (in_data.cmd == CMD_LOAD) begin
      push_item.op = OP_LOAD;
      keep         = 32'(in_data.star_index) < 32'(MAX_STARS);
    end else if (32'(in_data.star_index) < 32'(count)) begin
      push_item.op = OP_QUERY;
    end else begin
      push_item.op = OP_REJECT;
    end
  end

  assign busy = q_full;
  assign push = start & ~q_full & keep;

endmodule

FILE: hdl/sga_queue.sv
// Short command queue between front end and compute engine.
// Depends on sga_pkg.
module sga_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sga_pkg::q_item_t push_item,
  input  logic             pop,
  output sga_pkg::q_item_t head,
  output logic             empty,
  output logic             full
);
  import sga_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  q_item_t          slot_r [Q_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(Q_DEPTH));
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (32'(wp_r) == Q_DEPTH - 1) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (32'(rp_r) == Q_DEPTH - 1) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: hdl/sga_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sga_pkg for operand widths.
module sga_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sga_pkg::DIV_NUM_W-1:0] num,
  input  logic [sga_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [sga_pkg::DIV_NUM_W-1:0] quo
);
  import sga_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fit;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fit   = trial >= {1'b0, den_r};
  assign busy  = busy_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (32'(cnt_r) == DIV_NUM_W - 1) busy_r <= 1'b0;
    end
  end

endmodule

FILE: hdl/sga_back.sv
// Compute engine: star store, per-body force term sequencer, accumulators.
// Depends on sga_pkg and sga_div; pops commands from sga_queue.
module sga_back #(
  parameter int MAX_STARS = sga_pkg::MAX_STARS_DEF,
  localparam int CNT_W = $clog2(MAX_STARS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sga_pkg::cfg_t      cfg,
  input  logic [CNT_W-1:0]   count,
  input  logic               q_empty,
  input  sga_pkg::q_item_t   head,
  output logic               pop,
  output logic               out_valid,
  output sga_pkg::out_item_t out_data
);
  import sga_pkg::*;

  localparam int AW = $clog2(MAX_STARS);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_SELF  = 18'h00002,
    S_SELFQ = 18'h00004,
    S_NEXT  = 18'h00008,
    S_FETCH = 18'h00010,
    S_DIFF  = 18'h00020,
    S_SQX   = 18'h00040,
    S_SQY   = 18'h00080,
    S_R2    = 18'h00100,
    S_SQRT  = 18'h00200,
    S_UST   = 18'h00400,
    S_DIVU  = 18'h00800,
    S_MULX  = 18'h01000,
    S_MULY  = 18'h02000,
    S_TST   = 18'h04000,
    S_DIVT  = 18'h08000,
    S_ACC   = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  // star store
  logic signed [CRD_W-1:0] mem_x [MAX_STARS];
  logic signed [CRD_W-1:0] mem_y [MAX_STARS];
  logic [CRD_W-1:0]        mem_m [MAX_STARS];
  logic signed [CRD_W-1:0] rdx_q, rdy_q;
  logic [CRD_W-1:0]        rdm_q;
  logic [AW-1:0]           rd_addr;
  logic                    we;

  logic [IDX_W-1:0]        idx_r;
  logic signed [CRD_W-1:0] sx_r, sy_r;
  logic [47:0]             e2_r;
  logic                    is_c_r;
  logic [CNT_W-1:0]        j_r;
  logic [CRD_W-1:0]        bm_r;
  logic signed [32:0]      dx_r, dy_r;
  logic [48:0]             sqx_r, sqy_r;
  logic [49:0]             r2_r, r2_nxt;
  logic [63:0]             v_r;
  logic [33:0]             rem_r;
  logic [31:0]             root_r;
  logic [4:0]              scnt_r;
  logic [62:0]             mux_r, muy_r;
  logic signed [63:0]      ax_r, ay_r;
  logic                    sat_r;
  logic                    ov_r;
  out_item_t               od_r;

  logic [32:0] adx, ady, mul_a, mul_b;
  logic [65:0] prod;
  logic [35:0] sq_pre, sq_trial;
  logic        sq_fit;

  logic                 dv_start, dvx_busy, dvy_busy;
  logic [DIV_NUM_W-1:0] dvx_num, dvy_num, quox, quoy;
  logic [DIV_DEN_W-1:0] dv_den;
  logic [30:0]          ux, uy;
  logic [62:0]          tx, ty;
  logic signed [65:0]   stx, sty, sumx, sumy;
  logic signed [63:0]   clx, cly;
  logic                 satx, saty, clipx, clipy;

  assign pop = (state_r == S_IDLE) & ~q_empty;
  assign we  = pop & (head.op == OP_LOAD);

  assign rd_addr = (state_r == S_SELF) ? AW'(idx_r) : AW'(j_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[AW'(head.idx)] <= head.x;
      mem_y[AW'(head.idx)] <= head.y;
      mem_m[AW'(head.idx)] <= head.mass;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
    rdm_q <= mem_m[rd_addr];
  end

  assign adx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);

  // shared multiplier
  always_comb begin
    case (state_r)
      S_SELFQ: begin mul_a = 33'(cfg.softening_length); mul_b = 33'(cfg.softening_length); end
      S_SQX:   begin mul_a = adx; mul_b = adx; end
      S_SQY:   begin mul_a = ady; mul_b = ady; end
      S_MULX:  begin mul_a = 33'(bm_r); mul_b = 33'(ux); end
      S_MULY:  begin mul_a = 33'(bm_r); mul_b = 33'(uy); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign r2_nxt = 50'(sqx_r) + 50'(sqy_r) + 50'(e2_r);

  // digit-by-digit square root, two radicand bits per step
  assign sq_pre   = {rem_r, v_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_fit   = sq_pre >= sq_trial;

  assign dv_start = (state_r == S_UST) | (state_r == S_TST);
  assign dvx_num  = (state_r == S_UST) ? DIV_NUM_W'({adx, 29'd0}) : mux_r;
  assign dvy_num  = (state_r == S_UST) ? DIV_NUM_W'({ady, 29'd0}) : muy_r;
  assign dv_den   = (state_r == S_UST) ? DIV_DEN_W'(root_r) : {r2_r, 6'd0};

  sga_div u_divx (.clk, .rst_n, .start(dv_start), .num(dvx_num), .den(dv_den),
                  .busy(dvx_busy), .quo(quox));
  sga_div u_divy (.clk, .rst_n, .start(dv_start), .num(dvy_num), .den(dv_den),
                  .busy(dvy_busy), .quo(quoy));

  // direction cosine, clamped to one; with a zero root, each nonzero offset counts as one
  always_comb begin
    if (root_r == '0) begin
      ux = (adx != '0) ? U_ONE : '0;
      uy = (ady != '0) ? U_ONE : '0;
    end else begin
      ux = (quox > 63'(U_ONE)) ? U_ONE : quox[30:0];
      uy = (quoy > 63'(U_ONE)) ? U_ONE : quoy[30:0];
    end
  end

  assign tx = (mux_r == '0) ? '0 : (r2_r == '0) ? TERM_HUGE : quox;
  assign ty = (muy_r == '0) ? '0 : (r2_r == '0) ? TERM_HUGE : quoy;

  assign stx  = dx_r[32] ? -$signed({3'b000, tx}) : $signed({3'b000, tx});
  assign sty  = dy_r[32] ? -$signed({3'b000, ty}) : $signed({3'b000, ty});
  assign sumx = 66'(ax_r) + stx;
  assign sumy = 66'(ay_r) + sty;

  always_comb begin
    satx = 1'b1;
    saty = 1'b1;
    if (sumx > ACC_LIM)       clx = 64'(ACC_LIM);
    else if (sumx < -ACC_LIM) clx = 64'(-ACC_LIM);
    else begin clx = 64'(sumx); satx = 1'b0; end
    if (sumy > ACC_LIM)       cly = 64'(ACC_LIM);
    else if (sumy < -ACC_LIM) cly = 64'(-ACC_LIM);
    else begin cly = 64'(sumy); saty = 1'b0; end
  end

  assign clipx = (ax_r > OUT_MAX) | (ax_r < OUT_MIN);
  assign clipy = (ay_r > OUT_MAX) | (ay_r < OUT_MIN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (pop && head.op == OP_QUERY) state_nxt = S_SELF;
      S_SELF:  state_nxt = S_SELFQ;
      S_SELFQ: state_nxt = S_DIFF;
      S_NEXT: begin
        if (j_r == count)                     state_nxt = S_DONE;
        else if (32'(j_r) != 32'(idx_r))      state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_R2;
      S_R2:    state_nxt = S_SQRT;
      S_SQRT:  if (scnt_r == 5'd31) state_nxt = S_UST;
      S_UST:   state_nxt = S_DIVU;
      S_DIVU:  if (!dvx_busy && !dvy_busy) state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_TST;
      S_TST:   state_nxt = S_DIVT;
      S_DIVT:  if (!dvx_busy && !dvy_busy) state_nxt = S_ACC;
      S_ACC:   state_nxt = (is_c_r && !cfg.pairwise_enable) ? S_DONE : S_NEXT;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (pop && head.op == OP_REJECT) || (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        idx_r  <= head.idx;
        ax_r   <= '0;
        ay_r   <= '0;
        sat_r  <= 1'b0;
        is_c_r <= 1'b1;
        if (pop && head.op == OP_REJECT) begin
          od_r.result_index <= head.idx;
          od_r.acc_x        <= '0;
          od_r.acc_y        <= '0;
          od_r.saturated    <= 1'b0;
          od_r.index_error  <= 1'b1;
        end
      end
      S_SELFQ: begin
        sx_r <= rdx_q;
        sy_r <= rdy_q;
        e2_r <= prod[63:16];
      end
      S_NEXT: if (j_r != count && 32'(j_r) == 32'(idx_r)) j_r <= j_r + 1'b1;
      S_DIFF: begin
        if (is_c_r) begin
          dx_r <= 33'sd0 - 33'(sx_r);
          dy_r <= 33'sd0 - 33'(sy_r);
          bm_r <= cfg.central_mass;
        end else begin
          dx_r <= 33'(rdx_q) - 33'(sx_r);
          dy_r <= 33'(rdy_q) - 33'(sy_r);
          bm_r <= rdm_q;
        end
      end
      S_SQX: sqx_r <= prod[64:16];
      S_SQY: sqy_r <= prod[64:16];
      S_R2: begin
        r2_r   <= r2_nxt;
        v_r    <= {r2_nxt, 14'd0};
        rem_r  <= '0;
        root_r <= '0;
        scnt_r <= '0;
      end
      S_SQRT: begin
        v_r    <= {v_r[61:0], 2'b00};
        rem_r  <= sq_fit ? 34'(sq_pre - sq_trial) : sq_pre[33:0];
        root_r <= {root_r[30:0], sq_fit};
        scnt_r <= scnt_r + 1'b1;
      end
      S_MULX: mux_r <= prod[62:0];
      S_MULY: muy_r <= prod[62:0];
      S_ACC: begin
        ax_r  <= clx;
        ay_r  <= cly;
        sat_r <= sat_r | satx | saty;
        if (is_c_r) begin
          is_c_r <= 1'b0;
          j_r    <= '0;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_DONE: begin
        od_r.result_index <= idx_r;
        od_r.acc_x        <= clipx ? (ax_r[63] ? ACC_W'(OUT_MIN) : ACC_W'(OUT_MAX))
                                   : ax_r[ACC_W-1:0];
        od_r.acc_y        <= clipy ? (ay_r[63] ? ACC_W'(OUT_MIN) : ACC_W'(OUT_MAX))
                                   : ay_r[ACC_W-1:0];
        od_r.saturated    <= sat_r | clipx | clipy;
        od_r.index_error  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

FILE: hdl/softened_gravity_acceleration.sv
// Top level of the softened 2D gravity block: front end, queue, engine.
// Depends on sga_pkg, sga_front, sga_queue, sga_back (and sga_div below it).
//
// Usage:
//   Commands enter on in_data when start is high and busy is low. A load
//   (cmd 0) writes one star into the store; a query (cmd 1) reports the
//   acceleration on a stored star from the central mass plus, with pairwise
//   mode on, every other star below star_count.
//   Configuration goes through the APB port (psel/penable/pwrite/paddr/
//   pwdata, pready tied high), register i at byte address 4*i; write only
//   while no transaction is in flight.
//   busy rises when the two-entry command queue is full.
//   A load is written into the store as the engine pops it. A rejected query is
//   strobed on out_valid in the cycle right after it leaves the queue. A valid
//   query sums one term per contributing body (central mass plus each other star):
//   a 32-step square root and two divider passes of 63 quotient bits dominate each term.
//   Results appear for one cycle with out_valid; the receiver cannot stall.
//   Reset sets the registers (softening to 32'h0001_0000, pairwise on, the rest to zero),
//   clears the queue and sequencer; store contents stay undefined until loaded.
module softened_gravity_acceleration #(
  parameter int MAX_STARS = sga_pkg::MAX_STARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sga_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output sga_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sga_pkg::PADDR_W-1:0]  paddr,
  input  logic [sga_pkg::PDATA_W-1:0]  pwdata,
  output logic [sga_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import sga_pkg::*;

  localparam int CNT_W = $clog2(MAX_STARS + 1);

  logic             q_full, q_empty, push, pop;
  q_item_t          push_item, head;
  cfg_t             cfg;
  logic [CNT_W-1:0] count;

  sga_front #(.MAX_STARS(MAX_STARS)) u_front (
    .clk, .rst_n, .start, .busy, .in_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .q_full, .push, .push_item, .cfg, .count
  );

  sga_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .head,
    .empty(q_empty), .full(q_full)
  );

  sga_back #(.MAX_STARS(MAX_STARS)) u_back (
    .clk, .rst_n, .cfg, .count, .q_empty, .head, .pop, .out_valid, .out_data
  );

endmodule
